// ----- hw/rtl/pfms_pkg.sv -----
// ----------------------------------------------------------------------------
// pfms_pkg
// Shared types and constants of the Pareto front median selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfms_pkg;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_VALUE_BITS  = 32;
    localparam int FIELD_VAL_W     = 32;
    localparam int FIELD_IDX_W     = 8;
    localparam int FIELD_KEY_W     = 32;
    localparam int FRONT_W         = 7;

    typedef struct packed {
        logic [FIELD_VAL_W-1:0] delay_value;
        logic [FIELD_VAL_W-1:0] power_value;
        logic [FIELD_IDX_W-1:0] driven_cap_index;
        logic [FIELD_IDX_W-1:0] output_slew_index;
        logic [FIELD_IDX_W-1:0] load_cap_index;
        logic [FIELD_IDX_W-1:0] input_slew_index;
        logic [FIELD_KEY_W-1:0] pattern_key;
        logic                   last_entry;
    } pfms_in_req_t;

    typedef struct packed {
        logic [FIELD_VAL_W-1:0] sel_delay;
        logic [FIELD_VAL_W-1:0] sel_power;
        logic [FIELD_IDX_W-1:0] sel_driven_cap;
        logic [FIELD_IDX_W-1:0] sel_output_slew;
        logic [FIELD_IDX_W-1:0] sel_load_cap;
        logic [FIELD_IDX_W-1:0] sel_input_slew;
        logic [FIELD_KEY_W-1:0] sel_pattern;
        logic [FRONT_W-1:0]     front_size;
        logic                   overflow_flag;
    } pfms_out_req_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } pfms_state_t;

endpackage

// ----- hw/rtl/pfms_in_if.sv -----
// ----------------------------------------------------------------------------
// pfms_in_if
// Input channel of the selector: one candidate entry per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfms_in_if;
    import pfms_pkg::*;

    logic         valid;
    logic         ready;
    pfms_in_req_t req;

    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

// ----- hw/rtl/pfms_out_if.sv -----
// ----------------------------------------------------------------------------
// pfms_out_if
// Output channel of the selector: one selected entry per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfms_out_if;
    import pfms_pkg::*;

    logic          valid;
    logic          ready;
    pfms_out_req_t req;

    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

// ----- hw/rtl/pareto_front_median_select_core.sv -----
// ----------------------------------------------------------------------------
// pareto_front_median_select_core
// Loads candidate entries, finds the Pareto front and emits its median entry.
// ----------------------------------------------------------------------------
// The input channel carries one candidate entry per request. Entries are
// written to an entry memory in arrival order; entries beyond MAX_ENTRIES are
// dropped and set the overflow flag. A request with last_entry set starts the
// selection, and the input stays stalled until it finishes.
// Selection runs two passes over the n stored entries. Each pass takes every
// entry in turn and streams all n entries past it from the entry memory, one
// per cycle: the dominance pass always runs fully, the rank pass stops at the
// median entry. The time a set takes is bounded by the single read port of
// the entry memory.
// The result is held in an output register until the receiver takes it; a
// new set may be loaded meanwhile, and a finished selection waits for the
// register to free up. Reset empties the store and clears the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pareto_front_median_select_core #(
    parameter int MAX_ENTRIES = pfms_pkg::DEF_MAX_ENTRIES,
    parameter int VALUE_BITS  = pfms_pkg::DEF_VALUE_BITS
) (
    input logic     clk,
    input logic     rst_n,
    pfms_in_if.sink in_ch,
    pfms_out_if.source out_ch
);
    import pfms_pkg::*;

    localparam int IW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int VB  = VALUE_BITS;
    localparam int LOW = 4 * FIELD_IDX_W + FIELD_KEY_W;
    localparam int EW  = 2 * VB + LOW;

    function automatic logic [VB-1:0] f_delay(input logic [EW-1:0] e);
        f_delay = e[EW-1 -: VB];
    endfunction

    function automatic logic [VB-1:0] f_power(input logic [EW-1:0] e);
        f_power = e[LOW +: VB];
    endfunction

    function automatic logic dominates(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic no_worse;
        logic better;
        no_worse  = (f_delay(a) <= f_delay(b)) && (f_power(a) <= f_power(b));
        better    = (f_delay(a) < f_delay(b)) || (f_power(a) < f_power(b));
        dominates = no_worse && better;
    endfunction

    function automatic logic precedes(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic [FIELD_IDX_W-1:0] a_dc, b_dc, a_os, b_os, a_lc, b_lc, a_is, b_is;
        logic [FIELD_KEY_W-1:0] a_k, b_k;
        a_dc = a[LOW-1 -: FIELD_IDX_W];
        b_dc = b[LOW-1 -: FIELD_IDX_W];
        a_os = a[LOW-1-FIELD_IDX_W -: FIELD_IDX_W];
        b_os = b[LOW-1-FIELD_IDX_W -: FIELD_IDX_W];
        a_lc = a[FIELD_KEY_W+FIELD_IDX_W +: FIELD_IDX_W];
        b_lc = b[FIELD_KEY_W+FIELD_IDX_W +: FIELD_IDX_W];
        a_is = a[FIELD_KEY_W +: FIELD_IDX_W];
        b_is = b[FIELD_KEY_W +: FIELD_IDX_W];
        a_k  = a[FIELD_KEY_W-1:0];
        b_k  = b[FIELD_KEY_W-1:0];
        priority if (f_power(a) != f_power(b)) precedes = f_power(a) < f_power(b);
        else if (f_delay(a) != f_delay(b))     precedes = f_delay(a) < f_delay(b);
        else if (a_dc != b_dc)                 precedes = a_dc < b_dc;
        else if (a_os != b_os)                 precedes = a_os < b_os;
        else if (a_lc != b_lc)                 precedes = a_lc < b_lc;
        else if (a_is != b_is)                 precedes = a_is > b_is;
        else                                   precedes = a_k < b_k;
    endfunction

    pfms_state_t   state_reg, state_next;
    logic          rank_pass_reg, rank_pass_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] front_reg, front_next;
    logic [CW-1:0] target_reg, target_next;
    logic [CW-1:0] rank_reg, rank_next;
    logic          dom_reg, dom_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] jd_reg, jd_next;
    logic          jd_vld_reg, jd_vld_next;
    logic          iss_reg, iss_next;
    logic          first_reg, first_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic          cur_mark_reg, cur_mark_next;
    logic          out_valid_reg, out_valid_next;
    pfms_out_req_t out_reg, out_next;

    logic          ent_we;
    logic [IW-1:0] ent_waddr;
    logic [EW-1:0] ent_wdata;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] ent_rdata;
    logic          mark_we;
    logic          mark_wdata;
    logic          mark_rdata;

    logic          in_fire;
    logic [IW-1:0] last_idx;
    logic          dom_hit;
    logic          rank_hit;
    logic          dom_final;
    logic [CW-1:0] rank_final;
    logic [CW-1:0] front_final;
    logic          scan_end;

    pfms_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wdata),
        .rd_addr (rd_addr),
        .rd_data (ent_rdata)
    );

    pfms_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_mark_ram (
        .clk     (clk),
        .wr_en   (mark_we),
        .wr_addr (i_reg),
        .wr_data (mark_wdata),
        .rd_addr (rd_addr),
        .rd_data (mark_rdata)
    );

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.req   = out_reg;

    assign ent_waddr = cnt_reg[IW-1:0];
    assign ent_wdata = {VB'(in_ch.req.delay_value), VB'(in_ch.req.power_value),
                        in_ch.req.driven_cap_index, in_ch.req.output_slew_index,
                        in_ch.req.load_cap_index, in_ch.req.input_slew_index,
                        in_ch.req.pattern_key};
    assign ent_we    = in_fire && (cnt_reg < CW'(MAX_ENTRIES));
    assign last_idx  = IW'(cnt_reg - CW'(1));

    assign dom_hit   = jd_vld_reg && (jd_reg != i_reg) && dominates(ent_rdata, cur_reg);
    assign rank_hit  = jd_vld_reg && !mark_rdata && (jd_reg != i_reg) &&
                       (precedes(ent_rdata, cur_reg) ||
                        ((jd_reg < i_reg) && !precedes(cur_reg, ent_rdata)));
    assign dom_final   = dom_reg || dom_hit;
    assign rank_final  = rank_reg + CW'(rank_hit);
    assign front_final = front_reg + CW'(!dom_final);
    assign scan_end    = jd_vld_reg && (jd_reg == last_idx);

    assign mark_we    = (state_reg == ST_SCAN) && !rank_pass_reg && scan_end;
    assign mark_wdata = dom_final;

    always_comb
    begin
        state_next     = state_reg;
        rank_pass_next = rank_pass_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        front_next     = front_reg;
        target_next    = target_reg;
        rank_next      = rank_reg;
        dom_next       = dom_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jd_next        = j_reg;
        jd_vld_next    = 1'b0;
        iss_next       = iss_reg;
        first_next     = 1'b0;
        cur_next       = cur_reg;
        cur_mark_next  = cur_mark_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_addr        = j_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (ent_we)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_ch.req.last_entry)
                    begin
                        rank_pass_next = 1'b0;
                        i_next         = '0;
                        front_next     = '0;
                        state_next     = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                rd_addr    = i_reg;
                j_next     = '0;
                iss_next   = 1'b1;
                first_next = 1'b1;
                dom_next   = 1'b0;
                rank_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (first_reg)
                begin
                    cur_next      = ent_rdata;
                    cur_mark_next = mark_rdata;
                end
                if (iss_reg)
                begin
                    jd_vld_next = 1'b1;
                    if (j_reg == last_idx)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        j_next = j_reg + IW'(1);
                    end
                end
                if (!first_reg)
                begin
                    dom_next  = dom_final;
                    rank_next = rank_final;
                end
                if (scan_end)
                begin
                    if (!rank_pass_reg)
                    begin
                        front_next = front_final;
                        if (i_reg == last_idx)
                        begin
                            rank_pass_next = 1'b1;
                            i_next         = '0;
                            target_next    = (front_final - CW'(1)) >> 1;
                        end
                        else
                        begin
                            i_next = i_reg + IW'(1);
                        end
                        state_next = ST_FETCH;
                    end
                    else if (!cur_mark_reg && (rank_final == target_reg))
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next          = 1'b1;
                    out_next.sel_delay      = FIELD_VAL_W'(f_delay(cur_reg));
                    out_next.sel_power      = FIELD_VAL_W'(f_power(cur_reg));
                    out_next.sel_driven_cap = cur_reg[LOW-1 -: FIELD_IDX_W];
                    out_next.sel_output_slew = cur_reg[LOW-1-FIELD_IDX_W -: FIELD_IDX_W];
                    out_next.sel_load_cap   = cur_reg[FIELD_KEY_W+FIELD_IDX_W +: FIELD_IDX_W];
                    out_next.sel_input_slew = cur_reg[FIELD_KEY_W +: FIELD_IDX_W];
                    out_next.sel_pattern    = cur_reg[FIELD_KEY_W-1:0];
                    out_next.front_size     = FRONT_W'(front_reg);
                    out_next.overflow_flag  = ovf_reg;
                    cnt_next                = '0;
                    ovf_next                = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rank_pass_reg <= 1'b0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            jd_vld_reg    <= 1'b0;
            iss_reg       <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rank_pass_reg <= rank_pass_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            jd_vld_reg    <= jd_vld_next;
            iss_reg       <= iss_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg    <= front_next;
        target_reg   <= target_next;
        rank_reg     <= rank_next;
        dom_reg      <= dom_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        jd_reg       <= jd_next;
        cur_reg      <= cur_next;
        cur_mark_reg <= cur_mark_next;
        out_reg      <= out_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_ENTRIES))
        else $error("entry count exceeds store depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (cnt_reg == CW'(MAX_ENTRIES)))
        else $error("overflow set while store not full");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && (!out_valid_reg || out_ch.ready))
        |=> (cnt_reg == '0 && !ovf_reg && out_valid_reg))
        else $error("emit did not clear the set");

    a_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
        jd_vld_reg |-> (state_reg == ST_SCAN))
        else $error("streamed entry outside scan");

endmodule

// ----- hw/rtl/pfms_ram.sv -----
// ----------------------------------------------------------------------------
// pfms_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
